// File: design/qva_pkg.sv
// shared constants, types and saturation helpers for the quaternion vector alu
package qva_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int PAIR_BITS = PROD_BITS + 1;
    localparam int WIDE_BITS = PROD_BITS + 4;
    localparam int NUM_BITS  = WORD_BITS + FRAC_BITS;
    localparam int DIV_LAT   = NUM_BITS + 2;
    localparam int RAD_BITS  = PROD_BITS + 2;
    localparam int ROOT_BITS = RAD_BITS / 2;
    localparam int SQRT_LAT  = ROOT_BITS + 2;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_MULS = 4'd4;
    localparam logic [3:0] OP_DIVS = 4'd5;
    localparam logic [3:0] OP_HAM  = 4'd6;
    localparam logic [3:0] OP_CONJ = 4'd7;
    localparam logic [3:0] OP_NEG  = 4'd8;
    localparam logic [3:0] OP_ROT  = 4'd9;
    localparam logic [3:0] OP_MAG  = 4'd10;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [PROD_BITS-1:0] prod_t;
    typedef logic signed [PAIR_BITS-1:0] pair_t;
    typedef logic signed [WIDE_BITS-1:0] wide_t;

    typedef struct packed {
        word_t val;
        logic  ov;
    } sat_t;

    typedef struct packed {
        word_t val;
        logic  ov;
        logic  dz;
    } div_res_t;

    typedef struct packed {
        logic [3:0][WORD_BITS-1:0] c;
        logic                      ov;
        logic                      dz;
    } res_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam wide_t HALF_LSB = wide_t'(1) <<< (FRAC_BITS - 1);

    function automatic sat_t sat_word(input wide_t v);
        sat_t r;
        r.ov  = 1'b0;
        r.val = v[WORD_BITS-1:0];
        if (v < wide_t'(WORD_MIN))
        begin
            r.val = WORD_MIN;
            r.ov  = 1'b1;
        end
        else if (v > wide_t'(WORD_MAX))
        begin
            r.val = WORD_MAX;
            r.ov  = 1'b1;
        end
        return r;
    endfunction

    function automatic sat_t round_sat(input wide_t v);
        wide_t t;
        t = v + HALF_LSB;
        t = t >>> FRAC_BITS;
        return sat_word(t);
    endfunction

endpackage

// File: design/quaternion_vector_alu.sv
// top level: pipelined quaternion and 4-vector alu on q16.16 operands
// done pulses with the result once start has passed the valid pipeline and the done register
// throughput: one beat per cycle; busy stays low, the receiver cannot stall
// depth is set by the 48-stage divider, other paths are delayed to match it
// reset clears the valid bits and the done strobe; payload registers are not reset
module quaternion_vector_alu (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  logic [3:0]     req_type,
    input  qva_pkg::word_t a_x,
    input  qva_pkg::word_t a_y,
    input  qva_pkg::word_t a_z,
    input  qva_pkg::word_t a_w,
    input  qva_pkg::word_t b_x,
    input  qva_pkg::word_t b_y,
    input  qva_pkg::word_t b_z,
    input  qva_pkg::word_t b_w,
    input  qva_pkg::word_t scalar,
    output logic           done,
    output qva_pkg::word_t r_x,
    output qva_pkg::word_t r_y,
    output qva_pkg::word_t r_z,
    output qva_pkg::word_t r_w,
    output logic           overflow,
    output logic           div_zero
);

    localparam int S_MID = 4;
    localparam int S_ROT = 9;
    localparam int S_SQ  = 4 + qva_pkg::SQRT_LAT;
    localparam int S_FIN = qva_pkg::DIV_LAT;

    logic                 valid_pipe_reg [0:S_FIN];
    logic [3:0]           op_pipe_reg    [0:S_FIN];
    qva_pkg::word_t       a_pipe_reg     [0:7][0:3];
    qva_pkg::word_t       b_pipe_reg     [0:4][0:3];
    qva_pkg::word_t       s_reg;

    qva_pkg::word_t       y_op      [0:3][0:3];
    qva_pkg::prod_t       prod_next [0:3][0:3];
    qva_pkg::prod_t       prod_reg  [0:3][0:3];
    qva_pkg::pair_t       pp        [0:3][0:3];
    qva_pkg::wide_t       simp_sum  [0:3];
    qva_pkg::sat_t        simp_sat  [0:3];
    qva_pkg::res_t        simp_next;
    qva_pkg::res_t        simp_pipe_reg [1:3];

    qva_pkg::pair_t       pa_next [0:3];
    qva_pkg::pair_t       pb_next [0:3];
    qva_pkg::pair_t       pa_reg  [0:3];
    qva_pkg::pair_t       pb_reg  [0:3];
    qva_pkg::wide_t       v3_reg  [0:3];
    qva_pkg::sat_t        rs4     [0:3];
    qva_pkg::res_t        mid_next;
    qva_pkg::res_t        mid_pipe_reg [S_MID:S_FIN];

    qva_pkg::word_t       u4      [0:2];
    qva_pkg::word_t       b4      [0:3];
    qva_pkg::prod_t       wu5_reg [0:2];
    qva_pkg::prod_t       cp5_reg [0:2][0:1];
    qva_pkg::prod_t       wu6_reg [0:2];
    qva_pkg::pair_t       uu6_reg [0:2];
    qva_pkg::wide_t       t7_reg  [0:2];
    qva_pkg::wide_t       f8_reg  [0:2];
    logic                 rov_pipe_reg [5:8];
    qva_pkg::sat_t        rs9     [0:2];
    qva_pkg::res_t        rot_next;
    qva_pkg::res_t        rot_pipe_reg [S_ROT:S_FIN];

    qva_pkg::sat_t        sq_root;
    qva_pkg::res_t        sq_pipe_reg [S_SQ:S_FIN];

    qva_pkg::word_t       div_den [0:3];
    qva_pkg::div_res_t    div_res [0:3];
    qva_pkg::res_t        div_all;

    qva_pkg::res_t        fin_next;
    qva_pkg::res_t        res_reg;
    logic                 done_reg;

    assign busy = 1'b0;

    // control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= S_FIN; k++)
            begin
                valid_pipe_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            valid_pipe_reg[0] <= start && !busy;
            for (int k = 1; k <= S_FIN; k++)
            begin
                valid_pipe_reg[k] <= valid_pipe_reg[k-1];
            end
            done_reg <= valid_pipe_reg[S_FIN];
        end
    end

    // stage 1: partial products and the add/sub/negate/conjugate results
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                y_op[i][j] = b_pipe_reg[0][j];
                if (i == j && op_pipe_reg[0] == qva_pkg::OP_MULS)
                begin
                    y_op[i][j] = s_reg;
                end
                else if (i == j && op_pipe_reg[0] == qva_pkg::OP_MAG)
                begin
                    y_op[i][j] = a_pipe_reg[0][i];
                end
                prod_next[i][j] = qva_pkg::prod_t'(a_pipe_reg[0][i])
                                * qva_pkg::prod_t'(y_op[i][j]);
            end
        end
    end

    always_comb
    begin
        simp_next.ov = 1'b0;
        simp_next.dz = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            case (op_pipe_reg[0])
                qva_pkg::OP_ADD:
                begin
                    simp_sum[c] = qva_pkg::wide_t'(a_pipe_reg[0][c])
                                + qva_pkg::wide_t'(b_pipe_reg[0][c]);
                end
                qva_pkg::OP_SUB:
                begin
                    simp_sum[c] = qva_pkg::wide_t'(a_pipe_reg[0][c])
                                - qva_pkg::wide_t'(b_pipe_reg[0][c]);
                end
                qva_pkg::OP_NEG:
                begin
                    simp_sum[c] = -qva_pkg::wide_t'(a_pipe_reg[0][c]);
                end
                qva_pkg::OP_CONJ:
                begin
                    simp_sum[c] = (c == 3) ? qva_pkg::wide_t'(a_pipe_reg[0][c])
                                           : -qva_pkg::wide_t'(a_pipe_reg[0][c]);
                end
                default:
                begin
                    simp_sum[c] = '0;
                end
            endcase
            simp_sat[c]    = qva_pkg::sat_word(simp_sum[c]);
            simp_next.c[c] = simp_sat[c].val;
            simp_next.ov   = simp_next.ov | simp_sat[c].ov;
        end
    end

    // stage 2: pair sums
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                pp[i][j] = qva_pkg::pair_t'(prod_reg[i][j]);
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            pa_next[c] = '0;
            pb_next[c] = '0;
        end
        case (op_pipe_reg[1])
            qva_pkg::OP_HAM:
            begin
                pa_next[0] = pp[3][0] + pp[0][3];
                pb_next[0] = pp[1][2] - pp[2][1];
                pa_next[1] = pp[3][1] - pp[0][2];
                pb_next[1] = pp[1][3] + pp[2][0];
                pa_next[2] = pp[3][2] + pp[0][1];
                pb_next[2] = pp[2][3] - pp[1][0];
                pa_next[3] = pp[3][3] - pp[0][0];
                pb_next[3] = -(pp[1][1] + pp[2][2]);
            end
            qva_pkg::OP_MUL, qva_pkg::OP_MULS:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    pa_next[c] = pp[c][c];
                end
            end
            qva_pkg::OP_ROT:
            begin
                pa_next[0] = pp[2][1] - pp[1][2];
                pa_next[1] = pp[0][2] - pp[2][0];
                pa_next[2] = pp[1][0] - pp[0][1];
            end
            qva_pkg::OP_MAG:
            begin
                pa_next[0] = pp[0][0] + pp[1][1];
                pb_next[0] = pp[2][2] + pp[3][3];
            end
            default:
            begin
                pa_next[0] = '0;
            end
        endcase
    end

    // stage 4: round and saturate, pick the early result
    always_comb
    begin
        mid_next.ov = 1'b0;
        mid_next.dz = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            rs4[c] = qva_pkg::round_sat(v3_reg[c]);
            mid_next.c[c] = '0;
        end
        case (op_pipe_reg[3])
            qva_pkg::OP_MUL, qva_pkg::OP_MULS, qva_pkg::OP_HAM, qva_pkg::OP_ROT:
            begin
                for (int c = 0; c < 4; c++)
                begin
                    mid_next.c[c] = rs4[c].val;
                    mid_next.ov   = mid_next.ov | rs4[c].ov;
                end
            end
            qva_pkg::OP_ADD, qva_pkg::OP_SUB, qva_pkg::OP_NEG, qva_pkg::OP_CONJ:
            begin
                mid_next = simp_pipe_reg[3];
            end
            default:
            begin
                mid_next.ov = 1'b0;
            end
        endcase
    end

    // rotate, second pass: products with the rounded cross product u
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u4[i] = qva_pkg::word_t'(mid_pipe_reg[S_MID].c[i]);
        end
        for (int j = 0; j < 4; j++)
        begin
            b4[j] = b_pipe_reg[4][j];
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rs9[i] = qva_pkg::round_sat(f8_reg[i]);
            rot_next.c[i] = rs9[i].val;
        end
        rot_next.c[3] = '0;
        rot_next.ov   = rov_pipe_reg[8] | rs9[0].ov | rs9[1].ov | rs9[2].ov;
        rot_next.dz   = 1'b0;
    end

    // dividers, one per component
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            div_den[c] = (op_pipe_reg[0] == qva_pkg::OP_DIVS) ? s_reg : b_pipe_reg[0][c];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_div
        qva_divider u_div (
            .clk      (clk),
            .dividend (a_pipe_reg[0][g]),
            .divisor  (div_den[g]),
            .result   (div_res[g])
        );
    end

    always_comb
    begin
        div_all.ov = 1'b0;
        div_all.dz = 1'b0;
        for (int c = 0; c < 4; c++)
        begin
            div_all.c[c] = div_res[c].val;
            div_all.ov   = div_all.ov | div_res[c].ov;
            div_all.dz   = div_all.dz | div_res[c].dz;
        end
    end

    qva_sqrt u_sqrt (
        .clk      (clk),
        .radicand (v3_reg[0][qva_pkg::RAD_BITS-1:0]),
        .root     (sq_root)
    );

    // final select
    always_comb
    begin
        case (op_pipe_reg[S_FIN])
            qva_pkg::OP_ADD, qva_pkg::OP_SUB, qva_pkg::OP_MUL, qva_pkg::OP_MULS,
            qva_pkg::OP_HAM, qva_pkg::OP_CONJ, qva_pkg::OP_NEG:
            begin
                fin_next = mid_pipe_reg[S_FIN];
            end
            qva_pkg::OP_DIV, qva_pkg::OP_DIVS:
            begin
                fin_next = div_all;
            end
            qva_pkg::OP_ROT:
            begin
                fin_next = rot_pipe_reg[S_FIN];
            end
            qva_pkg::OP_MAG:
            begin
                fin_next = sq_pipe_reg[S_FIN];
            end
            default:
            begin
                fin_next = '0;
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        op_pipe_reg[0]   <= req_type;
        a_pipe_reg[0][0] <= a_x;
        a_pipe_reg[0][1] <= a_y;
        a_pipe_reg[0][2] <= a_z;
        a_pipe_reg[0][3] <= a_w;
        b_pipe_reg[0][0] <= b_x;
        b_pipe_reg[0][1] <= b_y;
        b_pipe_reg[0][2] <= b_z;
        b_pipe_reg[0][3] <= b_w;
        s_reg            <= scalar;
        for (int k = 1; k <= S_FIN; k++)
        begin
            op_pipe_reg[k] <= op_pipe_reg[k-1];
        end
        for (int k = 1; k <= 7; k++)
        begin
            a_pipe_reg[k] <= a_pipe_reg[k-1];
        end
        for (int k = 1; k <= 4; k++)
        begin
            b_pipe_reg[k] <= b_pipe_reg[k-1];
        end

        prod_reg         <= prod_next;
        simp_pipe_reg[1] <= simp_next;
        simp_pipe_reg[2] <= simp_pipe_reg[1];
        simp_pipe_reg[3] <= simp_pipe_reg[2];

        pa_reg <= pa_next;
        pb_reg <= pb_next;
        for (int c = 0; c < 4; c++)
        begin
            v3_reg[c] <= qva_pkg::wide_t'(pa_reg[c]) + qva_pkg::wide_t'(pb_reg[c]);
        end

        mid_pipe_reg[S_MID] <= mid_next;
        for (int k = S_MID + 1; k <= S_FIN; k++)
        begin
            mid_pipe_reg[k] <= mid_pipe_reg[k-1];
        end

        wu5_reg[0]    <= qva_pkg::prod_t'(b4[3]) * qva_pkg::prod_t'(u4[0]);
        wu5_reg[1]    <= qva_pkg::prod_t'(b4[3]) * qva_pkg::prod_t'(u4[1]);
        wu5_reg[2]    <= qva_pkg::prod_t'(b4[3]) * qva_pkg::prod_t'(u4[2]);
        cp5_reg[0][0] <= qva_pkg::prod_t'(b4[1]) * qva_pkg::prod_t'(u4[2]);
        cp5_reg[0][1] <= qva_pkg::prod_t'(b4[2]) * qva_pkg::prod_t'(u4[1]);
        cp5_reg[1][0] <= qva_pkg::prod_t'(b4[2]) * qva_pkg::prod_t'(u4[0]);
        cp5_reg[1][1] <= qva_pkg::prod_t'(b4[0]) * qva_pkg::prod_t'(u4[2]);
        cp5_reg[2][0] <= qva_pkg::prod_t'(b4[0]) * qva_pkg::prod_t'(u4[1]);
        cp5_reg[2][1] <= qva_pkg::prod_t'(b4[1]) * qva_pkg::prod_t'(u4[0]);
        rov_pipe_reg[5] <= mid_pipe_reg[S_MID].ov;
        for (int k = 6; k <= 8; k++)
        begin
            rov_pipe_reg[k] <= rov_pipe_reg[k-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            wu6_reg[i] <= wu5_reg[i];
            uu6_reg[i] <= qva_pkg::pair_t'(cp5_reg[i][0]) - qva_pkg::pair_t'(cp5_reg[i][1]);
            t7_reg[i]  <= (qva_pkg::wide_t'(wu6_reg[i]) + qva_pkg::wide_t'(uu6_reg[i])) <<< 1;
            f8_reg[i]  <= (qva_pkg::wide_t'(a_pipe_reg[7][i]) <<< qva_pkg::FRAC_BITS)
                        + t7_reg[i];
        end
        rot_pipe_reg[S_ROT] <= rot_next;
        for (int k = S_ROT + 1; k <= S_FIN; k++)
        begin
            rot_pipe_reg[k] <= rot_pipe_reg[k-1];
        end

        sq_pipe_reg[S_SQ].c[0] <= sq_root.val;
        sq_pipe_reg[S_SQ].c[1] <= '0;
        sq_pipe_reg[S_SQ].c[2] <= '0;
        sq_pipe_reg[S_SQ].c[3] <= '0;
        sq_pipe_reg[S_SQ].ov   <= sq_root.ov;
        sq_pipe_reg[S_SQ].dz   <= 1'b0;
        for (int k = S_SQ + 1; k <= S_FIN; k++)
        begin
            sq_pipe_reg[k] <= sq_pipe_reg[k-1];
        end

        res_reg <= fin_next;
    end

    assign done     = done_reg;
    assign r_x      = qva_pkg::word_t'(res_reg.c[0]);
    assign r_y      = qva_pkg::word_t'(res_reg.c[1]);
    assign r_z      = qva_pkg::word_t'(res_reg.c[2]);
    assign r_w      = qva_pkg::word_t'(res_reg.c[3]);
    assign overflow = res_reg.ov;
    assign div_zero = res_reg.dz;

endmodule

// File: design/qva_divider.sv
// pipelined restoring divider, one quotient bit per stage, with q-format saturation
module qva_divider (
    input  logic              clk,
    input  qva_pkg::word_t    dividend,
    input  qva_pkg::word_t    divisor,
    output qva_pkg::div_res_t result
);

    localparam int W = qva_pkg::WORD_BITS;
    localparam int N = qva_pkg::NUM_BITS;

    typedef struct packed {
        logic [W-1:0] rem;
        logic [N-1:0] num;
        logic [W-1:0] den;
        logic         neg;
        logic         dz;
        logic         a_pos;
        logic         a_neg;
    } dstage_t;

    dstage_t           st_reg  [0:N];
    dstage_t           st_next [0:N];
    logic [W:0]        trial   [1:N];
    logic [W-1:0]      a_mag;
    logic [W-1:0]      d_mag;
    qva_pkg::wide_t    q_wide;
    qva_pkg::sat_t     q_sat;
    qva_pkg::div_res_t result_next;
    qva_pkg::div_res_t result_reg;

    always_comb
    begin
        a_mag = dividend[W-1] ? (~dividend + 1'b1) : dividend;
        d_mag = divisor[W-1] ? (~divisor + 1'b1) : divisor;
        st_next[0].rem   = '0;
        st_next[0].num   = {a_mag, {qva_pkg::FRAC_BITS{1'b0}}};
        st_next[0].den   = d_mag;
        st_next[0].neg   = dividend[W-1] ^ divisor[W-1];
        st_next[0].dz    = (divisor == '0);
        st_next[0].a_pos = !dividend[W-1] && (dividend != '0);
        st_next[0].a_neg = dividend[W-1];
        for (int k = 0; k < N; k++)
        begin
            st_next[k+1]     = st_reg[k];
            trial[k+1]       = {st_reg[k].rem, st_reg[k].num[N-1]};
            st_next[k+1].num = {st_reg[k].num[N-2:0], 1'b0};
            if (trial[k+1] >= {1'b0, st_reg[k].den})
            begin
                st_next[k+1].rem    = W'(trial[k+1] - {1'b0, st_reg[k].den});
                st_next[k+1].num[0] = 1'b1;
            end
            else
            begin
                st_next[k+1].rem = trial[k+1][W-1:0];
            end
        end
    end

    always_comb
    begin
        q_wide = qva_pkg::wide_t'(st_reg[N].num);
        if (st_reg[N].neg)
        begin
            q_wide = -q_wide;
        end
        q_sat = qva_pkg::sat_word(q_wide);
        result_next.val = q_sat.val;
        result_next.ov  = q_sat.ov;
        result_next.dz  = 1'b0;
        if (st_reg[N].dz)
        begin
            result_next.ov = 1'b0;
            result_next.dz = 1'b1;
            if (st_reg[N].a_pos)
            begin
                result_next.val = qva_pkg::WORD_MAX;
            end
            else if (st_reg[N].a_neg)
            begin
                result_next.val = qva_pkg::WORD_MIN;
            end
            else
            begin
                result_next.val = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= N; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// File: design/qva_sqrt.sv
// pipelined digit-by-digit square root, one root bit per stage, rounded to nearest
module qva_sqrt (
    input  logic                          clk,
    input  logic [qva_pkg::RAD_BITS-1:0]  radicand,
    output qva_pkg::sat_t                 root
);

    localparam int R  = qva_pkg::RAD_BITS;
    localparam int RB = qva_pkg::ROOT_BITS;
    localparam int MB = RB + 3;

    typedef struct packed {
        logic [MB-1:0] rem;
        logic [RB-1:0] root;
        logic [R-1:0]  rad;
    } sstage_t;

    sstage_t         st_reg  [0:RB];
    sstage_t         st_next [0:RB];
    logic [MB-1:0]   rem2    [1:RB];
    logic [MB-1:0]   trial   [1:RB];
    logic [RB:0]     root_rnd;
    qva_pkg::sat_t   root_next;
    qva_pkg::sat_t   root_reg;

    always_comb
    begin
        st_next[0].rem  = '0;
        st_next[0].root = '0;
        st_next[0].rad  = radicand;
        for (int k = 0; k < RB; k++)
        begin
            rem2[k+1]  = {st_reg[k].rem[MB-3:0], st_reg[k].rad[R-1:R-2]};
            trial[k+1] = MB'({st_reg[k].root, 2'b01});
            st_next[k+1].rad = {st_reg[k].rad[R-3:0], 2'b00};
            if (rem2[k+1] >= trial[k+1])
            begin
                st_next[k+1].rem  = rem2[k+1] - trial[k+1];
                st_next[k+1].root = {st_reg[k].root[RB-2:0], 1'b1};
            end
            else
            begin
                st_next[k+1].rem  = rem2[k+1];
                st_next[k+1].root = {st_reg[k].root[RB-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        root_rnd = {1'b0, st_reg[RB].root};
        if (st_reg[RB].rem > MB'(st_reg[RB].root))
        begin
            root_rnd = root_rnd + 1'b1;
        end
        root_next = qva_pkg::sat_word(qva_pkg::wide_t'(root_rnd));
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k <= RB; k++)
        begin
            st_reg[k] <= st_next[k];
        end
        root_reg <= root_next;
    end

    assign root = root_reg;

endmodule

// File: design/qva_checker.sv
// port-level checks for the quaternion vector alu, bound to the top level
module qva_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic [3:0]     req_type,
    input qva_pkg::word_t a_x,
    input qva_pkg::word_t a_y,
    input qva_pkg::word_t a_z,
    input qva_pkg::word_t a_w,
    input qva_pkg::word_t b_x,
    input qva_pkg::word_t b_y,
    input qva_pkg::word_t b_z,
    input qva_pkg::word_t b_w,
    input qva_pkg::word_t scalar,
    input logic           done,
    input qva_pkg::word_t r_x,
    input qva_pkg::word_t r_y,
    input qva_pkg::word_t r_z,
    input qva_pkg::word_t r_w,
    input logic           overflow,
    input logic           div_zero
);

    localparam int LAT = qva_pkg::DIV_LAT + 2;
    localparam int CW  = $clog2(LAT + 1);

    logic [CW-1:0] warm_cnt_reg;
    logic          warm;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_cnt_reg <= '0;
        end
        else if (warm_cnt_reg != CW'(LAT))
        begin
            warm_cnt_reg <= warm_cnt_reg + 1'b1;
        end
    end

    assign warm = (warm_cnt_reg == CW'(LAT));

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> !busy)
        else $error("busy raised");

    a_one_beat_per_start: assert property (@(posedge clk) disable iff (!rst_n)
        warm |-> (done == $past(start, LAT)))
        else $error("done does not follow start at fixed latency");

    a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && div_zero) |->
            $past(req_type == qva_pkg::OP_DIV || req_type == qva_pkg::OP_DIVS, LAT))
        else $error("div_zero on a non-divide beat");

    a_mag_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(req_type == qva_pkg::OP_MAG, LAT)) |->
            (r_y == '0 && r_z == '0 && r_w == '0 && !r_x[qva_pkg::WORD_BITS-1]))
        else $error("magnitude beat malformed");

    a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (warm && done && $past(req_type > qva_pkg::OP_MAG, LAT)) |->
            (r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0 && !overflow && !div_zero))
        else $error("undefined opcode gave nonzero beat");

endmodule

bind quaternion_vector_alu qva_checker u_qva_checker (.*);
